### hdl/lfsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared constants, types and helpers of the lowest free slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    localparam int RECORDS   = 256;
    localparam int IDX_W     = 8;
    localparam int CAP_W     = 9;
    localparam int CMD_W     = 2;
    localparam int MAP_DEPTH = (RECORDS > (1 << IDX_W)) ? (1 << IDX_W) : RECORDS;
    localparam int WORD_W    = 16;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = (MAP_DEPTH + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAP_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NEXT  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic eval;
        logic wr_en;
        logic adv;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic scan_cmd;
        logic hit;
        logic last;
        logic write_req;
    } status_t;

    // map word contents after reset: all free except record zero
    function automatic logic [WORD_W-1:0] reset_word(input logic [WADDR_W-1:0] waddr);
        logic [WORD_W-1:0] w;
        w = '1;
        if (waddr == '0)
        begin
            w[0] = 1'b0;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

### hdl/lfsa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_if
// Request, response and capacity write channels of the slot allocator.
// ----------------------------------------------------------------------------
interface lfsa_req_if;
    logic                          valid;
    logic                          ready;
    logic [lfsa_pkg::CMD_W-1:0]    command;
    logic [lfsa_pkg::IDX_W-1:0]    slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

interface lfsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lfsa_pkg::IDX_W-1:0]    result_index;
    logic                          flag;

    modport source (output valid, output result_index, output flag, input ready);
    modport sink   (input valid, input result_index, input flag, output ready);
endinterface

interface lfsa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lfsa_pkg::CAP_W-1:0]    capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface
`default_nettype wire

### hdl/lfsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module lfsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### hdl/lfsa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_datapath
// Free map storage, word search, capacity register and result registers.
// ----------------------------------------------------------------------------
module lfsa_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [lfsa_pkg::CMD_W-1:0]    in_command,
    input  wire logic [lfsa_pkg::IDX_W-1:0]    in_slot_index,
    input  wire logic                          cfg_we,
    input  wire logic [lfsa_pkg::CAP_W-1:0]    cfg_capacity,
    input  wire lfsa_pkg::ctrl_t               ctrl,
    output      lfsa_pkg::status_t             status,
    output      logic [lfsa_pkg::IDX_W-1:0]    out_result_index,
    output      logic                          out_flag
);

    lfsa_pkg::cmd_t                        cmd_reg;
    logic [lfsa_pkg::IDX_W-1:0]            idx_reg;
    logic [lfsa_pkg::WADDR_W-1:0]          word_reg;
    logic [lfsa_pkg::WADDR_W-1:0]          word_next;
    logic [lfsa_pkg::CAP_W-1:0]            cap_reg;
    logic [lfsa_pkg::NUM_WORDS-1:0]        word_valid_reg;
    logic [lfsa_pkg::IDX_W-1:0]            res_reg;
    logic                                  flag_reg;
    logic [lfsa_pkg::BIT_W-1:0]            bitpos_reg;
    logic [lfsa_pkg::IDX_W-1:0]            out_index_reg;
    logic                                  out_flag_reg;

    logic [lfsa_pkg::WORD_W-1:0]           ram_rdata;
    logic [lfsa_pkg::WORD_W-1:0]           word_eff;
    logic [lfsa_pkg::WORD_W-1:0]           wr_word;
    logic [lfsa_pkg::WORD_W-1:0]           in_range;
    logic [lfsa_pkg::WORD_W-1:0]           cand;
    logic [lfsa_pkg::CAP_W-1:0]            cap_eff;
    logic [lfsa_pkg::CAP_W-1:0]            cap_m1;
    logic [lfsa_pkg::CAP_W-1:0]            last_word;
    logic [lfsa_pkg::CAP_W-1:0]            word_base;
    logic [lfsa_pkg::CAP_W-1:0]            lo_bound;
    logic [lfsa_pkg::BIT_W-1:0]            hit_bit;
    logic [lfsa_pkg::IDX_W-1:0]            hit_index;
    logic                                  hit;
    logic                                  usable;
    logic                                  is_alloc;
    logic                                  is_scan;
    logic                                  write_req;
    logic                                  check_flag;
    lfsa_pkg::cmd_t                        in_cmd;

    assign in_cmd = lfsa_pkg::cmd_t'(in_command);

    // capacity and map word valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= lfsa_pkg::CAP_RESET;
            word_valid_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_capacity;
            end
            if (ctrl.wr_en)
            begin
                word_valid_reg[word_reg] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            if (in_cmd == lfsa_pkg::CMD_ALLOC)
            begin
                word_next = '0;
            end
            else
            begin
                word_next = lfsa_pkg::WADDR_W'(in_slot_index >> lfsa_pkg::BIT_W);
            end
        end
        else if (ctrl.adv)
        begin
            word_next = word_reg + lfsa_pkg::WADDR_W'(1);
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (ctrl.load)
        begin
            cmd_reg <= in_cmd;
            idx_reg <= in_slot_index;
        end
        if (ctrl.eval)
        begin
            res_reg    <= (is_scan && hit) ? hit_index : '0;
            flag_reg   <= is_scan ? hit : check_flag;
            bitpos_reg <= is_alloc ? hit_bit : idx_reg[lfsa_pkg::BIT_W-1:0];
        end
        if (ctrl.out_load)
        begin
            out_index_reg <= res_reg;
            out_flag_reg  <= flag_reg;
        end
    end

    lfsa_ram #(
        .WIDTH (lfsa_pkg::WORD_W),
        .DEPTH (lfsa_pkg::NUM_WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (word_reg),
        .wr_data (wr_word),
        .rd_en   (ctrl.rd_en),
        .rd_addr (word_reg),
        .rd_data (ram_rdata)
    );

    // never-written words read as their reset contents
    assign word_eff = word_valid_reg[word_reg] ? ram_rdata : lfsa_pkg::reset_word(word_reg);

    always_comb
    begin
        wr_word = word_eff;
        wr_word[bitpos_reg] = (cmd_reg == lfsa_pkg::CMD_FREE);
    end

    assign cap_eff   = (cap_reg > lfsa_pkg::CAP_LIMIT) ? lfsa_pkg::CAP_LIMIT : cap_reg;
    assign cap_m1    = (cap_eff == '0) ? '0 : cap_eff - lfsa_pkg::CAP_W'(1);
    assign last_word = cap_m1 >> lfsa_pkg::BIT_W;
    assign word_base = lfsa_pkg::CAP_W'(word_reg) << lfsa_pkg::BIT_W;
    assign is_alloc  = (cmd_reg == lfsa_pkg::CMD_ALLOC);
    assign is_scan   = is_alloc || (cmd_reg == lfsa_pkg::CMD_NEXT);
    assign lo_bound  = is_alloc ? lfsa_pkg::CAP_W'(1)
                                : lfsa_pkg::CAP_W'(idx_reg) + lfsa_pkg::CAP_W'(1);

    always_comb
    begin
        for (int b = 0; b < lfsa_pkg::WORD_W; b++)
        begin
            in_range[b] = ((word_base + lfsa_pkg::CAP_W'(b)) >= lo_bound) &&
                          ((word_base + lfsa_pkg::CAP_W'(b)) < cap_eff);
        end
    end

    // alloc looks for free bits, next for allocated ones
    assign cand = (is_alloc ? word_eff : ~word_eff) & in_range;
    assign hit  = |cand;

    always_comb
    begin
        hit_bit = '0;
        for (int b = lfsa_pkg::WORD_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                hit_bit = lfsa_pkg::BIT_W'(b);
            end
        end
    end

    assign hit_index  = lfsa_pkg::IDX_W'(word_base | lfsa_pkg::CAP_W'(hit_bit));
    assign usable     = (idx_reg != '0) && (lfsa_pkg::CAP_W'(idx_reg) < cap_eff);
    assign check_flag = (cmd_reg == lfsa_pkg::CMD_CHECK) && usable &&
                        !word_eff[idx_reg[lfsa_pkg::BIT_W-1:0]];
    assign write_req  = (is_alloc && hit) || ((cmd_reg == lfsa_pkg::CMD_FREE) && usable);

    assign status.scan_cmd  = is_scan;
    assign status.hit       = hit;
    assign status.last      = (lfsa_pkg::CAP_W'(word_reg) >= last_word);
    assign status.write_req = write_req;

    assign out_result_index = out_index_reg;
    assign out_flag         = out_flag_reg;

endmodule
`default_nettype wire

### hdl/lfsa_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_controller
// Sequencer for map reads, word evaluation, write back and result hand-off.
// ----------------------------------------------------------------------------
module lfsa_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    input  wire lfsa_pkg::status_t status,
    output      lfsa_pkg::ctrl_t   ctrl
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ctrl.rd_en = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                ctrl.eval = 1'b1;
                priority if (status.write_req)
                begin
                    state_next = ST_WRITE;
                end
                else if (!status.scan_cmd || status.hit || status.last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ctrl.adv   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_WRITE:
            begin
                ctrl.wr_en = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.rd_en && ctrl.wr_en))
        else $error("map read and write in the same cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded over an untaken result");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in progress");

    a_write_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> $past(state_reg == ST_EVAL))
        else $error("map write not preceded by word evaluation");
`endif

endmodule
`default_nettype wire

### hdl/lowest_free_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// Bitmap slot allocator: alloc, free, check and next-allocated requests.
// ----------------------------------------------------------------------------
// sequence: check reads and evaluates one map word; free also writes it back, except
//   when the slot is ignored; alloc and next read and evaluate one 16-bit map word
//   at a time until a hit or the last word, and alloc writes back the word it hit
// requests: one at a time, taken only in idle; a scan reads each map word, then evaluates it
// reset: map reads as all free except record zero, capacity 256, no clearing pass
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lfsa_req_if.sink   req,
    lfsa_rsp_if.source rsp,
    lfsa_cfg_if.sink   cfg
);

    lfsa_pkg::ctrl_t   ctrl;
    lfsa_pkg::status_t status;

    assign cfg.ready = 1'b1;

    lfsa_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    lfsa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_command       (req.command),
        .in_slot_index    (req.slot_index),
        .cfg_we           (cfg.valid),
        .cfg_capacity     (cfg.capacity),
        .ctrl             (ctrl),
        .status           (status),
        .out_result_index (rsp.result_index),
        .out_flag         (rsp.flag)
    );

endmodule
`default_nettype wire
